[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/owbm_pkg.sv]
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int CFG_W               = 10;
    localparam int NUM_REGS            = 7;
    localparam int CFG_IDX_W           = 3;
    localparam int DEF_TICK_COUNT_BITS = 10;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_BUS_RESET = 2'd1,
        ACT_WRITE     = 2'd2,
        ACT_READ      = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_SLOT_START    = 3'd3,
        REG_WRITE_BIT     = 3'd4,
        REG_READ_SAMPLE   = 3'd5,
        REG_READ_TAIL     = 3'd6
    } t_reg_idx;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] t_cfg_regs;

    // Entry 0 is the rightmost element.
    localparam t_cfg_regs CFG_RESET = {
        10'd50, 10'd15, 10'd70, 10'd2, 10'd500, 10'd30, 10'd600
    };

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W_START  = 4'd4,
        PH_W_BIT    = 4'd5,
        PH_W_REL    = 4'd6,
        PH_R_START  = 4'd7,
        PH_R_WAIT   = 4'd8,
        PH_R_TAIL   = 4'd9
    } t_phase;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] write_byte;
        logic       line_level;
    } t_owbm_item;

    typedef struct packed {
        logic       pull_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_byte;
    } t_owbm_res;

endpackage

[rtl/owbm_in_if.sv]
`timescale 1ns / 1ps

interface owbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] write_byte;
    logic       line_level;

    modport source (output valid, output action, output write_byte, output line_level,
                    input ready);
    modport sink   (input valid, input action, input write_byte, input line_level,
                    output ready);
endinterface

[rtl/owbm_out_if.sv]
`timescale 1ns / 1ps

interface owbm_out_if;
    logic       valid;
    logic       ready;
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_seen;
    logic [7:0] read_byte;

    modport source (output valid, output pull_low, output busy_res, output done_res,
                    output presence_seen, output read_byte, input ready);
    modport sink   (input valid, input pull_low, input busy_res, input done_res,
                    input presence_seen, input read_byte, output ready);
endinterface

[rtl/owbm_cfg.sv]
`timescale 1ns / 1ps

module owbm_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [owbm_pkg::CFG_W-1:0]         i_cfg_data,
    output owbm_pkg::t_cfg_regs                o_regs
);

    owbm_pkg::t_cfg_regs r_regs;

    // Index past the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= owbm_pkg::CFG_RESET;
        end else if (i_cfg_we && (i_cfg_idx < owbm_pkg::CFG_IDX_W'(owbm_pkg::NUM_REGS))) begin
            r_regs[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign o_regs = r_regs;

endmodule

[rtl/owbm_engine.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module owbm_engine #(
    parameter int TICK_COUNT_BITS = owbm_pkg::DEF_TICK_COUNT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  owbm_pkg::t_owbm_item i_item,
    input  owbm_pkg::t_cfg_regs  i_regs,
    output owbm_pkg::t_owbm_res  o_res
);

    localparam int LEN_W = (TICK_COUNT_BITS > owbm_pkg::CFG_W) ? TICK_COUNT_BITS
                                                                : owbm_pkg::CFG_W;
    localparam logic [LEN_W-1:0] CAP = LEN_W'((1 << TICK_COUNT_BITS) - 1);

    owbm_pkg::t_phase             r_phase, n_phase, s_phase;
    logic [TICK_COUNT_BITS-1:0]   r_tick, n_tick, s_tick;
    logic [2:0]                   r_bit, n_bit, s_bit;
    logic [7:0]                   r_shift, n_shift, s_shift;
    logic                         r_presence, n_presence, s_presence;
    logic [7:0]                   r_read, n_read;

    owbm_pkg::t_reg_idx           len_sel;
    logic [LEN_W-1:0]             len_ext;
    logic [LEN_W-1:0]             len_clamp;
    logic [TICK_COUNT_BITS-1:0]   len;
    logic [TICK_COUNT_BITS:0]     tick_inc;
    logic                         tick_end;
    logic [TICK_COUNT_BITS-1:0]   tick_next;
    logic                         pull, busy, done;

    // Command launch: an idle tick with a command is already the first tick of the command.
    always_comb begin
        s_phase    = r_phase;
        s_tick     = r_tick;
        s_bit      = r_bit;
        s_shift    = r_shift;
        s_presence = r_presence;
        if (r_phase == owbm_pkg::PH_IDLE &&
            owbm_pkg::t_action'(i_item.action) != owbm_pkg::ACT_NONE) begin
            s_tick = '0;
            s_bit  = '0;
            unique case (owbm_pkg::t_action'(i_item.action))
                owbm_pkg::ACT_BUS_RESET: begin
                    s_phase    = owbm_pkg::PH_RST_LOW;
                    s_presence = 1'b0;
                end
                owbm_pkg::ACT_WRITE: begin
                    s_phase = owbm_pkg::PH_W_START;
                    s_shift = i_item.write_byte;
                end
                owbm_pkg::ACT_READ: begin
                    s_phase = owbm_pkg::PH_R_START;
                    s_shift = '0;
                end
                default: begin
                    s_phase = r_phase;
                end
            endcase
        end
    end

    // Phase length: clamp to the counter range, zero counts as one tick.
    always_comb begin
        unique case (s_phase)
            owbm_pkg::PH_RST_WAIT:                         len_sel = owbm_pkg::REG_PRESENCE_WAIT;
            owbm_pkg::PH_RST_TAIL:                         len_sel = owbm_pkg::REG_RESET_TAIL;
            owbm_pkg::PH_W_START, owbm_pkg::PH_R_START:    len_sel = owbm_pkg::REG_SLOT_START;
            owbm_pkg::PH_W_BIT:                            len_sel = owbm_pkg::REG_WRITE_BIT;
            owbm_pkg::PH_R_WAIT:                           len_sel = owbm_pkg::REG_READ_SAMPLE;
            owbm_pkg::PH_R_TAIL:                           len_sel = owbm_pkg::REG_READ_TAIL;
            default:                                       len_sel = owbm_pkg::REG_RESET_LOW;
        endcase
        len_ext   = LEN_W'(i_regs[len_sel]);
        len_clamp = (len_ext > CAP) ? CAP : len_ext;
        len       = TICK_COUNT_BITS'(len_clamp);
        if (len == '0) begin
            len = TICK_COUNT_BITS'(1);
        end
        tick_inc  = {1'b0, s_tick} + (TICK_COUNT_BITS+1)'(1);
        tick_end  = (tick_inc >= {1'b0, len});
        tick_next = tick_end ? '0 : tick_inc[TICK_COUNT_BITS-1:0];
    end

    always_comb begin
        n_phase    = s_phase;
        n_tick     = s_tick;
        n_bit      = s_bit;
        n_shift    = s_shift;
        n_presence = s_presence;
        n_read     = r_read;
        pull       = 1'b0;
        busy       = (s_phase != owbm_pkg::PH_IDLE);
        done       = 1'b0;
        unique case (s_phase)
            owbm_pkg::PH_IDLE: begin
            end
            owbm_pkg::PH_RST_LOW: begin
                pull   = 1'b1;
                n_tick = tick_next;
                if (tick_end) n_phase = owbm_pkg::PH_RST_WAIT;
            end
            owbm_pkg::PH_RST_WAIT: begin
                n_tick = tick_next;
                if (tick_end) begin
                    n_presence = !i_item.line_level;
                    n_phase    = owbm_pkg::PH_RST_TAIL;
                end
            end
            owbm_pkg::PH_RST_TAIL: begin
                n_tick = tick_next;
                if (tick_end) begin
                    done    = 1'b1;
                    n_phase = owbm_pkg::PH_IDLE;
                end
            end
            owbm_pkg::PH_W_START: begin
                pull   = 1'b1;
                n_tick = tick_next;
                if (tick_end) n_phase = owbm_pkg::PH_W_BIT;
            end
            owbm_pkg::PH_W_BIT: begin
                pull   = !s_shift[0];
                n_tick = tick_next;
                if (tick_end) n_phase = owbm_pkg::PH_W_REL;
            end
            owbm_pkg::PH_W_REL: begin
                // single released tick, then next bit or finish
                n_tick  = '0;
                n_shift = {1'b0, s_shift[7:1]};
                if (s_bit == '1) begin
                    done    = 1'b1;
                    n_bit   = '0;
                    n_phase = owbm_pkg::PH_IDLE;
                end else begin
                    n_bit   = s_bit + 3'd1;
                    n_phase = owbm_pkg::PH_W_START;
                end
            end
            owbm_pkg::PH_R_START: begin
                pull   = 1'b1;
                n_tick = tick_next;
                if (tick_end) n_phase = owbm_pkg::PH_R_WAIT;
            end
            owbm_pkg::PH_R_WAIT: begin
                n_tick = tick_next;
                if (tick_end) begin
                    n_shift = {i_item.line_level, s_shift[7:1]};
                    n_phase = owbm_pkg::PH_R_TAIL;
                end
            end
            owbm_pkg::PH_R_TAIL: begin
                n_tick = tick_next;
                if (tick_end) begin
                    if (s_bit == '1) begin
                        n_read  = s_shift;
                        done    = 1'b1;
                        n_bit   = '0;
                        n_phase = owbm_pkg::PH_IDLE;
                    end else begin
                        n_bit   = s_bit + 3'd1;
                        n_phase = owbm_pkg::PH_R_START;
                    end
                end
            end
            default: begin
                n_phase = owbm_pkg::PH_IDLE;
                n_tick  = '0;
                busy    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= owbm_pkg::PH_IDLE;
            r_tick     <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_presence <= 1'b0;
            r_read     <= '0;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_presence <= n_presence;
            r_read     <= n_read;
        end
    end

    assign o_res = '{pull_low:  pull,
                     busy:      busy,
                     done:      done,
                     presence:  n_presence,
                     read_byte: n_read};

    `ASSERT_IMP(a_idle_tick_clear, i_clk, i_rst_n,
                r_phase == owbm_pkg::PH_IDLE, r_tick == '0)
    `ASSERT_IMP(a_idle_bit_clear, i_clk, i_rst_n,
                r_phase == owbm_pkg::PH_IDLE, r_bit == '0)
    `ASSERT_IMP(a_release_tick_clear, i_clk, i_rst_n,
                r_phase == owbm_pkg::PH_W_REL, r_tick == '0)

endmodule

[rtl/one_wire_bus_master_core.sv]
`timescale 1ns / 1ps
// 1-Wire bus master core: bus reset, write byte and read byte, one transaction per us tick.
// Input channel i_in: one transaction per microsecond tick with the command (action), the
//   byte to write and the bus level sampled on that tick. A command is taken only while
//   the master is idle; a command that arrives during a busy command is dropped.
// Output channel o_out: exactly one transaction per input transaction, in order, with the
//   pin drive (pull_low), busy/done flags, the last presence result and the last read byte.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data writes the seven phase-length registers
//   (ticks); index 7 is ignored. Write only while no transaction is in flight.
// Pipeline: two register stages (input register, then the phase sequencer feeding the
//   result register); a stall on o_out can hold a taken transaction in the input register.
// Throughput: one transaction per cycle; the sequencer advances whenever the input
//   register holds a tick and the result register is empty or being drained.
// Stall: when o_out.ready is low the result holds, the input register fills, and then
//   i_in.ready drops; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous): both stages empty, sequencer idle, presence and read
//   byte cleared, config registers back to their defaults.
`include "assert_macros.svh"
module one_wire_bus_master_core #(
    parameter int TICK_COUNT_BITS = owbm_pkg::DEF_TICK_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    owbm_in_if.sink                        i_in,
    owbm_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [owbm_pkg::CFG_W-1:0]     i_cfg_data
);

    owbm_pkg::t_cfg_regs  regs;
    owbm_pkg::t_owbm_item r_item;
    owbm_pkg::t_owbm_res  res;
    owbm_pkg::t_owbm_res  r_res;
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic                 adv;

    // Sequencer steps when a tick is waiting and the result slot is free or being drained.
    assign adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= '{action:     i_in.action,
                        write_byte: i_in.write_byte,
                        line_level: i_in.line_level};
        end
    end

    owbm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_regs     (regs)
    );

    owbm_engine #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_item),
        .i_regs  (regs),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pull_low      = r_res.pull_low;
    assign o_out.busy_res      = r_res.busy;
    assign o_out.done_res      = r_res.done;
    assign o_out.presence_seen = r_res.presence;
    assign o_out.read_byte     = r_res.read_byte;

    `ASSERT_NXT(a_adv_fills_out, i_clk, i_rst_n, adv, r_out_valid)
    `ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, !i_in.ready,
                r_in_valid && r_out_valid && !o_out.ready)
    `ASSERT_IMP(a_done_is_busy, i_clk, i_rst_n, r_out_valid && r_res.done, r_res.busy)

endmodule
